>>> sv/mfst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfst_pkg
// Shared widths, register indexes, pipeline payload types and the output
// saturation helper for the Manning friction source-term block.
// ----------------------------------------------------------------------------
package mfst_pkg;

    localparam int DATA_W     = 32;   // Q16.16 fields
    localparam int CFG_W      = 24;   // widest configuration register
    localparam int SQ_W       = 64;   // sum of squared momenta, cube-root radicand
    localparam int ROOT_STEPS = 32;   // square-root digits, one per stage
    localparam int CBRT_STEPS = 22;   // cube-root digits, one per stage
    localparam int CBRT_W     = 22;   // cube root of a 64-bit radicand
    localparam int K_W        = 48;   // g * n^2
    localparam int NUM_W      = 111;  // k * |m| * |Q|
    localparam int DEN_W      = 94;   // h^2 * h^(1/3) * 2^8
    localparam int DIV_STEPS  = 32;   // quotient bits, one per stage

    localparam logic [CFG_W-1:0] GRAVITY_RESET   = 24'd642908;
    localparam logic [CFG_W-1:0] ROUGHNESS_RESET = 24'd285213;

    typedef enum logic [0:0] {
        REG_GRAVITY   = 1'b0,
        REG_ROUGHNESS = 1'b1
    } cfg_reg_t;

    // Per-node data that rides alongside the arithmetic
    typedef struct packed {
        logic                     wet;
        logic                     zero_depth;
        logic                     x_pos;
        logic                     x_neg;
        logic                     y_pos;
        logic                     y_neg;
        logic signed [DATA_W-1:0] rhs_x;
        logic signed [DATA_W-1:0] rhs_y;
    } side_t;

    // Apply the friction magnitude against the momentum sign and clamp.
    // Returns {clamped, value}.
    function automatic logic [DATA_W:0] axis_out(
        input logic signed [DATA_W-1:0] rhs,
        input logic                     pos,
        input logic                     neg,
        input logic [DATA_W-1:0]        mag
    );
        logic signed [DATA_W+1:0] r;
        logic [DATA_W:0]          res;
        r = {{2{rhs[DATA_W-1]}}, rhs};
        if (pos) begin
            r = r - $signed({2'b00, mag});
        end else if (neg) begin
            r = r + $signed({2'b00, mag});
        end
        if (r > 34'sd2147483647) begin
            res = {1'b1, 32'h7FFF_FFFF};
        end else if (r < -34'sd2147483648) begin
            res = {1'b1, 32'h8000_0000};
        end else begin
            res = {1'b0, r[DATA_W-1:0]};
        end
        return res;
    endfunction

endpackage

>>> sv/manning_friction_source_term.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manning_friction_source_term
// Subtracts Manning bottom friction g*n^2*q*|Q|/h^(7/3) from both momentum
// right-hand sides of each wet node; dry nodes pass through.
// ----------------------------------------------------------------------------
//  channel | dir | ports                    | contents
//  --------+-----+--------------------------+-------------------------------
//  s_      | in  | tvalid tready tdata tuser| one mesh node per word
//  m_      | out | tvalid tready tdata tuser| updated right-hand sides
//  cfg_    | in  | wr_en index wdata        | gravity, roughness
//
//  One word enters per cycle unless the output stalls; from acceptance to m_tvalid
//  it passes through the 32-stage square root and the 32-stage divider in series.
//  aresetn (synchronous) empties the pipeline and restores both registers.
//  When m_tvalid is high and m_tready low the whole pipeline holds and
//  s_tready drops; bubbles travel with their stage.
// ----------------------------------------------------------------------------
module manning_friction_source_term (
    input  logic                         aclk,
    input  logic                         aresetn,
    // tdata: depth[31:0], momentum_x[63:32], momentum_y[95:64],
    //        rhs_x_in[127:96], rhs_y_in[159:128]
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [159:0]                 s_tdata,
    input  logic [0:0]                   s_tuser,   // wet[0]
    // tdata: rhs_x_out[31:0], rhs_y_out[63:32]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [63:0]                  m_tdata,
    output logic [0:0]                   m_tuser,   // saturated[0]
    input  logic                         cfg_wr_en,
    input  logic [0:0]                   cfg_index,
    input  logic [mfst_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int DW          = mfst_pkg::DATA_W;
    localparam int ST_ROOT_IN  = 2;
    localparam int ST_ROOT_OUT = ST_ROOT_IN + mfst_pkg::ROOT_STEPS;
    localparam int ST_OVF      = ST_ROOT_OUT + 5;
    localparam int ST_OUT      = ST_OVF + mfst_pkg::DIV_STEPS + 1;

    logic en;

    logic [mfst_pkg::CFG_W-1:0] gravity_reg;
    logic [mfst_pkg::CFG_W-1:0] roughness_reg;
    logic [mfst_pkg::CFG_W-1:0] n2_reg;
    logic [mfst_pkg::K_W-1:0]   k_reg;

    logic [ST_OUT:0]       vld_reg;
    mfst_pkg::side_t       side_reg [ST_OUT];
    mfst_pkg::side_t       side_in;
    logic [DW-1:0]         h_reg  [ST_ROOT_OUT+1];
    logic [DW-1:0]         ax_reg [ST_ROOT_OUT+1];
    logic [DW-1:0]         ay_reg [ST_ROOT_OUT+1];
    logic [DW-1:0]         in_ax;
    logic [DW-1:0]         in_ay;

    logic [mfst_pkg::SQ_W-1:0]   sqx_reg;
    logic [mfst_pkg::SQ_W-1:0]   sqy_reg;
    logic [mfst_pkg::SQ_W-1:0]   sum_reg;
    logic [DW-1:0]               root_s;
    logic [mfst_pkg::CBRT_W-1:0] root_c;

    logic [63:0]                 px_reg;
    logic [63:0]                 py_reg;
    logic [63:0]                 hh_reg;
    logic [mfst_pkg::CBRT_W-1:0] c_reg;

    logic [55:0] ppx00_reg, ppx01_reg, ppx10_reg, ppx11_reg;
    logic [55:0] ppy00_reg, ppy01_reg, ppy10_reg, ppy11_reg;
    logic [53:0] dlo_reg, dhi_reg;

    logic [87:0]                 xa_reg, xb_reg, ya_reg, yb_reg;
    logic [mfst_pkg::DEN_W-1:0]  den37_reg;
    logic [mfst_pkg::NUM_W-1:0]  numx_reg, numy_reg;
    logic [mfst_pkg::DEN_W-1:0]  den38_reg;
    logic [mfst_pkg::NUM_W-1:0]  numx39_reg, numy39_reg;
    logic [mfst_pkg::DEN_W-1:0]  den39_reg;
    logic [mfst_pkg::DIV_STEPS:0] ovfx_reg;
    logic [mfst_pkg::DIV_STEPS:0] ovfy_reg;
    logic [DW-1:0]               qx;
    logic [DW-1:0]               qy;

    logic [DW-1:0] rhs_x_reg, rhs_x_next;
    logic [DW-1:0] rhs_y_reg, rhs_y_next;
    logic          sat_reg, sat_next;

    localparam int PAD_W = mfst_pkg::DEN_W + mfst_pkg::DIV_STEPS - mfst_pkg::NUM_W;

    // Advance everything unless a finished word is waiting
    assign en       = !vld_reg[ST_OUT] || m_tready;
    assign s_tready = en;

    // Configuration and the derived g*n^2 factor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg   <= mfst_pkg::GRAVITY_RESET;
            roughness_reg <= mfst_pkg::ROUGHNESS_RESET;
        end else if (cfg_wr_en) begin
            case (mfst_pkg::cfg_reg_t'(cfg_index))
                mfst_pkg::REG_GRAVITY:   gravity_reg   <= cfg_wdata;
                mfst_pkg::REG_ROUGHNESS: roughness_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        n2_reg <= mfst_pkg::CFG_W'((48'(roughness_reg) * 48'(roughness_reg)) >> 24);
        k_reg  <= 48'(gravity_reg) * 48'(n2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[ST_OUT-1:0], s_tvalid};
        end
    end

    assign in_ax = s_tdata[63]  ? (~s_tdata[63:32] + 32'd1) : s_tdata[63:32];
    assign in_ay = s_tdata[95]  ? (~s_tdata[95:64] + 32'd1) : s_tdata[95:64];

    always_comb begin
        side_in.wet        = s_tuser[0];
        side_in.zero_depth = (s_tdata[31:0] == '0);
        side_in.x_pos      = !s_tdata[63] && (s_tdata[63:32] != '0);
        side_in.x_neg      = s_tdata[63];
        side_in.y_pos      = !s_tdata[95] && (s_tdata[95:64] != '0);
        side_in.y_neg      = s_tdata[95];
        side_in.rhs_x      = s_tdata[127:96];
        side_in.rhs_y      = s_tdata[159:128];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < ST_OUT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            h_reg[0]  <= s_tdata[31:0];
            ax_reg[0] <= in_ax;
            ay_reg[0] <= in_ay;
            for (int i = 1; i <= ST_ROOT_OUT; i++) begin
                h_reg[i]  <= h_reg[i-1];
                ax_reg[i] <= ax_reg[i-1];
                ay_reg[i] <= ay_reg[i-1];
            end

            // squared momenta, then their sum
            sqx_reg <= 64'(ax_reg[0]) * 64'(ax_reg[0]);
            sqy_reg <= 64'(ay_reg[0]) * 64'(ay_reg[0]);
            sum_reg <= sqx_reg + sqy_reg;

            // |m| * |Q| per axis, h^2
            px_reg <= 64'(ax_reg[ST_ROOT_OUT]) * 64'(root_s);
            py_reg <= 64'(ay_reg[ST_ROOT_OUT]) * 64'(root_s);
            hh_reg <= 64'(h_reg[ST_ROOT_OUT]) * 64'(h_reg[ST_ROOT_OUT]);
            c_reg  <= root_c;

            // partial products of k * (|m| * |Q|) and h^2 * h^(1/3)
            ppx00_reg <= 56'(k_reg[23:0])  * 56'(px_reg[31:0]);
            ppx01_reg <= 56'(k_reg[23:0])  * 56'(px_reg[63:32]);
            ppx10_reg <= 56'(k_reg[47:24]) * 56'(px_reg[31:0]);
            ppx11_reg <= 56'(k_reg[47:24]) * 56'(px_reg[63:32]);
            ppy00_reg <= 56'(k_reg[23:0])  * 56'(py_reg[31:0]);
            ppy01_reg <= 56'(k_reg[23:0])  * 56'(py_reg[63:32]);
            ppy10_reg <= 56'(k_reg[47:24]) * 56'(py_reg[31:0]);
            ppy11_reg <= 56'(k_reg[47:24]) * 56'(py_reg[63:32]);
            dlo_reg   <= 54'(hh_reg[31:0])  * 54'(c_reg);
            dhi_reg   <= 54'(hh_reg[63:32]) * 54'(c_reg);

            xa_reg    <= 88'(ppx00_reg) + {ppx01_reg, 32'd0};
            xb_reg    <= 88'(ppx10_reg) + {ppx11_reg, 32'd0};
            ya_reg    <= 88'(ppy00_reg) + {ppy01_reg, 32'd0};
            yb_reg    <= 88'(ppy10_reg) + {ppy11_reg, 32'd0};
            den37_reg <= {86'(dlo_reg) + {dhi_reg, 32'd0}, 8'd0};

            numx_reg  <= mfst_pkg::NUM_W'(112'(xa_reg) + {xb_reg, 24'd0});
            numy_reg  <= mfst_pkg::NUM_W'(112'(ya_reg) + {yb_reg, 24'd0});
            den38_reg <= den37_reg;

            // quotient would not fit in 32 bits
            ovfx_reg <= {ovfx_reg[mfst_pkg::DIV_STEPS-1:0],
                         {{PAD_W{1'b0}}, numx_reg} >= {den38_reg, 32'd0}};
            ovfy_reg <= {ovfy_reg[mfst_pkg::DIV_STEPS-1:0],
                         {{PAD_W{1'b0}}, numy_reg} >= {den38_reg, 32'd0}};
            numx39_reg <= numx_reg;
            numy39_reg <= numy_reg;
            den39_reg  <= den38_reg;

            rhs_x_reg <= rhs_x_next;
            rhs_y_reg <= rhs_y_next;
            sat_reg   <= sat_next;
        end
    end

    mfst_roots u_roots (
        .aclk     (aclk),
        .en       (en),
        .sq_in    (sum_reg),
        .cube_in  ({h_reg[ST_ROOT_IN], 32'd0}),
        .sqrt_out (root_s),
        .cbrt_out (root_c)
    );

    mfst_div u_div_x (
        .aclk     (aclk),
        .en       (en),
        .num_in   (numx39_reg),
        .den_in   (den39_reg),
        .quot_out (qx)
    );

    mfst_div u_div_y (
        .aclk     (aclk),
        .en       (en),
        .num_in   (numy39_reg),
        .den_in   (den39_reg),
        .quot_out (qy)
    );

    always_comb begin
        mfst_pkg::side_t sd;
        logic [DW-1:0]   tx;
        logic [DW-1:0]   ty;
        logic [DW:0]     rx;
        logic [DW:0]     ry;
        sd = side_reg[ST_OUT-1];
        // zero depth or an oversized quotient forces the largest magnitude
        tx = (sd.zero_depth || ovfx_reg[mfst_pkg::DIV_STEPS]) ? '1 : qx;
        ty = (sd.zero_depth || ovfy_reg[mfst_pkg::DIV_STEPS]) ? '1 : qy;
        rx = mfst_pkg::axis_out(sd.rhs_x, sd.x_pos, sd.x_neg, tx);
        ry = mfst_pkg::axis_out(sd.rhs_y, sd.y_pos, sd.y_neg, ty);
        if (sd.wet) begin
            rhs_x_next = rx[DW-1:0];
            rhs_y_next = ry[DW-1:0];
            sat_next   = sd.zero_depth || ovfx_reg[mfst_pkg::DIV_STEPS]
                         || ovfy_reg[mfst_pkg::DIV_STEPS] || rx[DW] || ry[DW];
        end else begin
            rhs_x_next = sd.rhs_x;
            rhs_y_next = sd.rhs_y;
            sat_next   = 1'b0;
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = {rhs_y_reg, rhs_x_reg};
    assign m_tuser  = sat_reg;

endmodule

>>> sv/mfst_roots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfst_roots
// Pipelined digit-by-digit square root of the squared momentum magnitude and
// cube root of the shifted depth, one result digit per stage.
// ----------------------------------------------------------------------------
module mfst_roots (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [mfst_pkg::SQ_W-1:0]      sq_in,
    input  logic [mfst_pkg::SQ_W-1:0]      cube_in,
    output logic [mfst_pkg::DATA_W-1:0]    sqrt_out,
    output logic [mfst_pkg::CBRT_W-1:0]    cbrt_out
);

    logic [mfst_pkg::SQ_W-1:0]   sx_reg [mfst_pkg::ROOT_STEPS];
    logic [mfst_pkg::SQ_W-1:0]   sr_reg [mfst_pkg::ROOT_STEPS];
    logic [mfst_pkg::SQ_W-1:0]   cx_reg [mfst_pkg::ROOT_STEPS];
    logic [mfst_pkg::CBRT_W-1:0] cy_reg [mfst_pkg::ROOT_STEPS];

    for (genvar j = 0; j < mfst_pkg::ROOT_STEPS; j++) begin : g_step
        localparam logic [mfst_pkg::SQ_W-1:0] BIT = 64'd1 << (62 - 2 * j);

        logic [mfst_pkg::SQ_W-1:0]   sx_in;
        logic [mfst_pkg::SQ_W-1:0]   sr_in;
        logic [mfst_pkg::SQ_W-1:0]   cx_in;
        logic [mfst_pkg::CBRT_W-1:0] cy_in;
        logic [mfst_pkg::SQ_W-1:0]   trial;
        logic                        s_ge;
        logic [mfst_pkg::SQ_W-1:0]   sx_next;
        logic [mfst_pkg::SQ_W-1:0]   sr_next;
        logic [mfst_pkg::SQ_W-1:0]   cx_next;
        logic [mfst_pkg::CBRT_W-1:0] cy_next;

        if (j == 0) begin : g_first
            assign sx_in = sq_in;
            assign sr_in = '0;
            assign cx_in = cube_in;
            assign cy_in = '0;
        end else begin : g_rest
            assign sx_in = sx_reg[j-1];
            assign sr_in = sr_reg[j-1];
            assign cx_in = cx_reg[j-1];
            assign cy_in = cy_reg[j-1];
        end

        assign trial   = sr_in + BIT;
        assign s_ge    = (sx_in >= trial);
        assign sx_next = s_ge ? (sx_in - trial) : sx_in;
        assign sr_next = s_ge ? ((sr_in >> 1) + BIT) : (sr_in >> 1);

        if (j < mfst_pkg::CBRT_STEPS) begin : g_cbrt
            localparam int SH = 63 - 3 * j;
            logic [mfst_pkg::CBRT_W-1:0] y2;
            logic [43:0]                 yy;
            logic [45:0]                 b;
            logic                        c_ge;
            assign y2      = {cy_in[mfst_pkg::CBRT_W-2:0], 1'b0};
            assign yy      = 44'(y2) * 44'(y2 + 22'd1);
            assign b       = {1'b0, yy, 1'b0} + {2'b00, yy} + 46'd1;
            assign c_ge    = ((cx_in >> SH) >= 64'(b));
            assign cx_next = c_ge ? (cx_in - (64'(b) << SH)) : cx_in;
            assign cy_next = y2 + {21'd0, c_ge};
        end else begin : g_hold
            assign cx_next = cx_in;
            assign cy_next = cy_in;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[j] <= sx_next;
                sr_reg[j] <= sr_next;
                cx_reg[j] <= cx_next;
                cy_reg[j] <= cy_next;
            end
        end
    end

    assign sqrt_out = sr_reg[mfst_pkg::ROOT_STEPS-1][mfst_pkg::DATA_W-1:0];
    assign cbrt_out = cy_reg[mfst_pkg::ROOT_STEPS-1];

endmodule

>>> sv/mfst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfst_div
// Pipelined restoring divider: one quotient bit per stage; correct only when
// the quotient is below 2^32, which the divider itself does not check.
// ----------------------------------------------------------------------------
module mfst_div (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [mfst_pkg::NUM_W-1:0]    num_in,
    input  logic [mfst_pkg::DEN_W-1:0]    den_in,
    output logic [mfst_pkg::DATA_W-1:0]   quot_out
);

    localparam int CMP_W = mfst_pkg::DEN_W + mfst_pkg::DIV_STEPS;

    logic [mfst_pkg::NUM_W-1:0]  rem_reg [mfst_pkg::DIV_STEPS];
    logic [mfst_pkg::DEN_W-1:0]  den_reg [mfst_pkg::DIV_STEPS];
    logic [mfst_pkg::DATA_W-1:0] q_reg   [mfst_pkg::DIV_STEPS];

    for (genvar j = 0; j < mfst_pkg::DIV_STEPS; j++) begin : g_step
        localparam int SH = mfst_pkg::DIV_STEPS - 1 - j;

        logic [mfst_pkg::NUM_W-1:0]  rem_in;
        logic [mfst_pkg::DEN_W-1:0]  den_in_s;
        logic [mfst_pkg::DATA_W-1:0] q_in;
        logic [CMP_W-1:0]            dsh;
        logic                        ge;

        if (j == 0) begin : g_first
            assign rem_in   = num_in;
            assign den_in_s = den_in;
            assign q_in     = '0;
        end else begin : g_rest
            assign rem_in   = rem_reg[j-1];
            assign den_in_s = den_reg[j-1];
            assign q_in     = q_reg[j-1];
        end

        assign dsh = CMP_W'(den_in_s) << SH;
        assign ge  = (CMP_W'(rem_in) >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? (rem_in - dsh[mfst_pkg::NUM_W-1:0]) : rem_in;
                den_reg[j] <= den_in_s;
                q_reg[j]   <= {q_in[mfst_pkg::DATA_W-2:0], ge};
            end
        end
    end

    assign quot_out = q_reg[mfst_pkg::DIV_STEPS-1];

endmodule

>>> sv/mfst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfst_checker
// Port-level checks on the friction block's flow control and reset.
// ----------------------------------------------------------------------------
module mfst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_ready_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is drained");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_stall_prop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is held");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

endmodule

bind manning_friction_source_term mfst_checker u_mfst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/manning_friction_source_term_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manning_friction_source_term_test
// Streams mesh nodes through the friction block under several gravity and
// roughness settings and checks every output word against an in-bench
// fixed-point predictor, with random bubbles on both sides and one long
// output back-pressure stretch.
// ----------------------------------------------------------------------------
module manning_friction_source_term_test;

    localparam int NUM_RANDOM = 1330;
    localparam int QUIET_TAIL = 150;
    localparam int LATENCY    = 80;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        bit               wet;
        bit [31:0]        depth;
        bit signed [31:0] mx;
        bit signed [31:0] my;
        bit signed [31:0] rx;
        bit signed [31:0] ry;
    } node_t;

    typedef struct {
        bit [31:0] rx;
        bit [31:0] ry;
        bit        sat;
    } rhs_t;

    typedef struct {
        node_t n;
        bit    known;
        rhs_t  r;
    } row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [159:0]               s_tdata = '0;
    logic [0:0]                 s_tuser = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [63:0]                m_tdata;
    logic [0:0]                 m_tuser;
    logic                       cfg_wr_en = 1'b0;
    logic [0:0]                 cfg_index = '0;
    logic [mfst_pkg::CFG_W-1:0] cfg_wdata = '0;

    bit [23:0] gravity_q = mfst_pkg::GRAVITY_RESET;
    bit [23:0] roughness_q = mfst_pkg::ROUGHNESS_RESET;
    rhs_t      rhs_due[$];
    rhs_t      typed_due[$];
    bit        typed_known[$];
    int        errors = 0;
    int        results = 0;
    int        sat_seen = 0;
    int        dry_seen = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;
    bit        hold_req = 1'b0;

    always #6 aclk = ~aclk;

    manning_friction_source_term u_top (.*);

    function automatic bit [63:0] sqrt_floor(bit [63:0] x);
        bit [63:0] y = 0, t;
        for (int i = 31; i >= 0; i--) begin
            t = y | (64'd1 << i);
            if (t * t <= x) y = t;
        end
        return y;
    endfunction

    function automatic bit [63:0] cbrt_floor(bit [63:0] x);
        bit [127:0] y = 0, t;
        for (int i = 21; i >= 0; i--) begin
            t = y | (128'd1 << i);
            if (t * t * t <= {64'd0, x}) y = t;
        end
        return y[63:0];
    endfunction

    // returns {saturated, value}
    function automatic bit [32:0] friction_axis(bit signed [31:0] rhs, bit signed [31:0] m,
                                                bit [63:0] s, bit [63:0] k,
                                                bit [127:0] den, bit zero);
        bit signed [63:0] m64 = m;
        bit signed [63:0] r = rhs;
        bit [63:0]  mag = (m64 < 0) ? -m64 : m64;
        bit [127:0] q;
        bit [63:0]  t;
        bit         sat = 0;
        if (zero) begin
            t = 64'hFFFF_FFFF;
            sat = 1;
        end else begin
            q = ({64'd0, k} * {64'd0, mag * s}) / den;
            if (q > 128'hFFFF_FFFF) begin
                t = 64'hFFFF_FFFF;
                sat = 1;
            end else begin
                t = q[63:0];
            end
        end
        if (m64 > 0) r = r - $signed(t);
        else if (m64 < 0) r = r + $signed(t);
        if (r > 64'sd2147483647) begin
            r = 64'sd2147483647;
            sat = 1;
        end else if (r < -64'sd2147483648) begin
            r = -64'sd2147483648;
            sat = 1;
        end
        return {sat, r[31:0]};
    endfunction

    function automatic rhs_t predict_rhs(node_t n);
        rhs_t       o;
        bit [63:0]  ax, ay, s, c, k, n2;
        bit [127:0] den;
        bit [32:0]  px, py;
        if (!n.wet) begin
            o.rx = n.rx;
            o.ry = n.ry;
            o.sat = 0;
            return o;
        end
        ax = n.mx[31] ? -{{32{1'b1}}, n.mx} : {32'd0, n.mx};
        ay = n.my[31] ? -{{32{1'b1}}, n.my} : {32'd0, n.my};
        s = sqrt_floor(ax * ax + ay * ay);
        c = cbrt_floor({n.depth, 32'd0});
        n2 = ({40'd0, roughness_q} * {40'd0, roughness_q}) >> 24;
        k = {40'd0, gravity_q} * n2;
        den = (({96'd0, n.depth} * {96'd0, n.depth}) * {64'd0, c}) << 8;
        px = friction_axis(n.rx, n.mx, s, k, den, n.depth == 0);
        py = friction_axis(n.ry, n.my, s, k, den, n.depth == 0);
        o.rx = px[31:0];
        o.ry = py[31:0];
        o.sat = px[32] | py[32];
        return o;
    endfunction

    task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %h expected %h", results, what, got, want);
    endtask

    // Input side: predict every accepted word; output side: check in order.
    always @(posedge aclk) begin
        node_t n;
        rhs_t  w;
        if (aresetn && s_tvalid && s_tready) begin
            n.wet = s_tuser[0];
            {n.ry, n.rx, n.my, n.mx, n.depth} = s_tdata;
            rhs_due.push_back(predict_rhs(n));
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (rhs_due.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[31:0], 32'd0);
            end else begin
                w = rhs_due.pop_front();
                if (m_tdata[31:0] !== w.rx) report_mismatch("rhs_x", m_tdata[31:0], w.rx);
                if (m_tdata[63:32] !== w.ry) report_mismatch("rhs_y", m_tdata[63:32], w.ry);
                if (m_tuser[0] !== w.sat)
                    report_mismatch("saturated", {31'd0, m_tuser[0]}, {31'd0, w.sat});
                if (m_tuser[0]) sat_seen++;
            end
            // hand-typed expectations for the directed rows
            if (typed_due.size() != 0) begin
                w = typed_due.pop_front();
                if (typed_known.pop_front()) begin
                    if (m_tdata[31:0] !== w.rx) report_mismatch("typed rhs_x", m_tdata[31:0], w.rx);
                    if (m_tdata[63:32] !== w.ry)
                        report_mismatch("typed rhs_y", m_tdata[63:32], w.ry);
                    if (m_tuser[0] !== w.sat)
                        report_mismatch("typed saturated", {31'd0, m_tuser[0]}, {31'd0, w.sat});
                end
            end
            results++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Output ready: random bursts of back-pressure, plus one long hold-off.
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(mfst_pkg::cfg_reg_t idx, bit [23:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == mfst_pkg::REG_GRAVITY) gravity_q = val;
        else roughness_q = val;
    endtask

    task automatic send_node(node_t n, bit stalls);
        @(negedge aclk);
        if (stalls && !quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= n.wet;
        s_tdata <= {n.ry, n.rx, n.my, n.mx, n.depth};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (rhs_due.size() != 0) @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    function automatic bit [31:0] pick_word(int shape);
        case (shape)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0004_0000);
            2: return -$urandom_range(0, 32'h0004_0000);
            3: return $urandom_range(0, 32'h0100_0000);
            default: return -$urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    function automatic node_t random_node();
        node_t n;
        n.wet = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 9))
            0: n.depth = $urandom;
            1: n.depth = 0;
            2: n.depth = $urandom_range(1, 32'h0000_1000);
            default: n.depth = $urandom_range(32'h0000_4000, 32'h0020_0000);
        endcase
        n.mx = pick_word($urandom_range(0, 4));
        n.my = pick_word($urandom_range(0, 4));
        n.rx = pick_word($urandom_range(0, 4));
        n.ry = pick_word($urandom_range(0, 4));
        if ($urandom_range(0, 9) == 0) n.mx = 0;
        return n;
    endfunction

    row_t directed[] = '{
        // dry nodes pass straight through
        '{'{0, 32'h0001_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh1234_5678, -32'sh0765_4321},
          1, '{32'h1234_5678, 32'hF89A_BCDF, 0}},
        '{'{0, 32'hFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000},
          1, '{32'h7FFF_FFFF, 32'h8000_0000, 0}},
        // wet with zero depth: clamp against the momentum sign, or pass through where it is zero
        '{'{1, 32'h0, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_1000, 32'sh0000_1000},
          1, '{32'h8000_0000, 32'h7FFF_FFFF, 1}},
        '{'{1, 32'h0, 32'sh0, 32'sh0, 32'sh0000_5555, -32'sh0000_5555},
          1, '{32'h0000_5555, 32'hFFFF_AAAB, 1}},
        '{'{1, 32'h0, 32'sh7FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 32'sh8000_0000},
          1, '{32'h8000_0000, 32'h8000_0000, 1}},
        '{'{1, 32'h0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
          1, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1}},
        // wet, still water: no friction
        '{'{1, 32'h0001_0000, 32'sh0, 32'sh0, 32'sh0000_2000, -32'sh0000_2000},
          1, '{32'h0000_2000, 32'hFFFF_E000, 0}},
        // ordinary flow and the extremes of depth and momentum
        '{'{1, 32'h0001_0000, 32'sh0001_0000, 32'sh0000_8000, 32'sh0, 32'sh0}, 0, '{0, 0, 0}},
        '{'{1, 32'h0000_8000, -32'sh0002_0000, 32'sh0001_0000, 32'sh0, 32'sh0}, 0, '{0, 0, 0}},
        '{'{1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0, 32'sh0}, 0, '{0, 0, 0}},
        '{'{1, 32'h0000_0001, 32'sh0000_0001, 32'sh0, 32'sh0, 32'sh0}, 0, '{0, 0, 0}},
        '{'{1, 32'h0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000},
          0, '{0, 0, 0}},
        '{'{1, 32'h0000_1000, 32'sh0010_0000, -32'sh0010_0000, 32'sh8000_0000, 32'sh7FFF_FFFF},
          0, '{0, 0, 0}},
        '{'{1, 32'h0100_0000, -32'sh0100_0000, -32'sh0000_0001, 32'sh0, 32'sh0}, 0, '{0, 0, 0}}
    };

    initial begin
        bit [23:0] grav_set[4];
        bit [23:0] rough_set[4];
        int        per_phase;
        int        sent;
        node_t     n;
        grav_set  = '{mfst_pkg::GRAVITY_RESET, 24'd0, 24'hFFFFFF, 24'd0};
        rough_set = '{mfst_pkg::ROUGHNESS_RESET, 24'hFFFFFF, 24'd0, 24'd0};
        per_phase = NUM_RANDOM / 4;
        sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            typed_due.push_back(directed[i].r);
            typed_known.push_back(directed[i].known);
            if (!directed[i].n.wet) dry_seen++;
            send_node(directed[i].n, 1);
        end
        drain();
        grav_set[3] = 24'($urandom_range(32'h0004_0000, 32'h00FF_FFFF));
        rough_set[3] = 24'($urandom_range(32'h0000_1000, 32'h00FF_FFFF));
        for (int p = 0; p < 4; p++) begin
            write_reg(mfst_pkg::REG_GRAVITY, grav_set[p]);
            write_reg(mfst_pkg::REG_ROUGHNESS, rough_set[p]);
            for (int i = 0; i < per_phase; i++) begin
                n = random_node();
                if (p == 1 && i == 40) hold_req = 1'b1;
                if (p == 3 && i == per_phase - QUIET_TAIL) quiet = 1'b1;
                if (!n.wet) dry_seen++;
                send_node(n, 1);
                sent++;
            end
            drain();
        end
        $display("covered %0d directed and %0d random nodes over 4 register settings",
                 directed.size(), sent);
        $display("%0d results checked, %0d saturated, %0d dry", results, sat_seen, dry_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
sv/mfst_pkg.sv
sv/mfst_roots.sv
sv/mfst_div.sv
sv/manning_friction_source_term.sv
sv/mfst_checker.sv
verif/manning_friction_source_term_test.sv
